### src/mhal_pkg.sv
package mhal_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  localparam int MASK_W      = 8;
  localparam int IDX_W       = 3;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD_OK = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_CHANGE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]         sensor;
    logic               above;
    logic signed [31:0] limit;
    logic [30:0]        band;
    logic [7:0]         pin;
  } slot_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   slot_index;
    logic [7:0]         out_pin;
    logic               level;
    logic [MASK_W-1:0]  triggered_mask;
    logic               last;
  } res_t;

endpackage

### src/mhal_ifs.sv
interface mhal_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         sensor_id;
  logic signed [31:0] sample_value;
  logic               above_not_below;
  logic signed [31:0] limit;
  logic [30:0]        band;
  logic [7:0]         pin;

  modport source(output valid, operation, sensor_id, sample_value, above_not_below, limit,
                 band, pin, input ready);
  modport sink(input valid, operation, sensor_id, sample_value, above_not_below, limit,
               band, pin, output ready);
endinterface

interface mhal_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] slot_index;
  logic [7:0] out_pin;
  logic       level;
  logic [7:0] triggered_mask;
  logic       last;

  modport source(output valid, kind, slot_index, out_pin, level, triggered_mask, last,
                 input ready);
  modport sink(input valid, kind, slot_index, out_pin, level, triggered_mask, last,
               output ready);
endinterface

### src/multichannel_hysteresis_alarm.sv
// Multichannel hysteresis alarm: a table of ALERT_SLOTS alarm slots. An add item takes the
// next free slot (sensor id, above/below direction, Q16.16 limit and band, output pin), clears
// its flag and returns one result; a full table returns one rejection. A sample item is checked
// against the used slots in index order, one slot per cycle while the result side does not
// stall, through a single compare unit fed from the slot memory; each flag change returns one
// result (at most eight per sample) and the final result of an item carries last. A sample
// lasts as long as the scan of the used slots through the memory read port, plus any stalls
// on the result side. Items are taken only while the block is idle. Every result carries
// the triggered flags of slots 0 to 7 as they stand after that result.
module multichannel_hysteresis_alarm #(
  parameter int ALERT_SLOTS = 8
) (
  input logic          clk,
  input logic          rst,
  mhal_item_if.sink    items,
  mhal_result_if.source results
);
  import mhal_pkg::*;

  localparam int IW = (ALERT_SLOTS > 1) ? $clog2(ALERT_SLOTS) : 1;
  localparam int CW = $clog2(ALERT_SLOTS + 1);
  localparam int PW = (ALERT_SLOTS < MASK_W) ? MASK_W : ALERT_SLOTS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADD   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [7:0]         sensor_id;
    logic signed [31:0] sample_value;
    logic               above_not_below;
    logic signed [31:0] limit;
    logic [30:0]        band;
    logic [7:0]         pin;
  } item_t;

  state_t                 state;
  item_t                  cur;
  logic [CW-1:0]          used;
  logic [ALERT_SLOTS-1:0] trig;
  logic [ALERT_SLOTS-1:0] trig_next;
  logic [IW-1:0]          scan_idx;
  logic [CNT_W-1:0]       cnt;
  logic                   pend_valid;
  res_t                   pend;
  logic                   out_valid;
  res_t                   out_res;

  // scan and handshake control
  logic                 out_free;
  logic                 out_load;
  logic                 full;
  logic [CW-1:0]        scan_ext;
  logic                 in_range;
  logic                 is_final;
  logic                 hit_raw;
  logic                 hit;
  logic                 stall;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  slot_t                wr_data;
  slot_t                rd_data;
  logic [PW-1:0]        trig_pad;
  logic [MASK_W-1:0]    mask_next;

  mhal_slot_ram #(
    .DEPTH(ALERT_SLOTS),
    .AW   (IW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(used[IW-1:0]),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mhal_eval u_eval (
    .slot        (rd_data),
    .triggered   (trig[scan_idx]),
    .sensor_id   (cur.sensor_id),
    .sample_value(cur.sample_value),
    .hit         (hit_raw)
  );

  always_comb begin
    out_free = !out_valid || results.ready;
    full     = (used == CW'(ALERT_SLOTS));
    scan_ext = CW'(scan_idx);
    in_range = (scan_ext < used);
    is_final = ((scan_ext + CW'(1)) == used);
    hit      = (state == S_SCAN) && in_range && hit_raw;
    // a new change needs the held result to move out first
    stall    = hit && pend_valid && !out_free;

    // output register loads on an add, on a held change handed on, or on the final flush
    out_load = ((state == S_ADD) && out_free) ||
               (hit && !stall && pend_valid && (cnt < CNT_W'(MAX_RESULTS))) ||
               ((state == S_FLUSH) && pend_valid && out_free);

    // read address runs one slot ahead so the memory delivers a slot every cycle while the scan is not stalled
    if (state == S_IDLE) begin
      rd_addr = '0;
    end else if (state == S_SCAN && in_range && !stall && !is_final) begin
      rd_addr = scan_idx + IW'(1);
    end else begin
      rd_addr = scan_idx;
    end

    wr_en           = (state == S_ADD) && out_free && !full;
    wr_data.sensor  = cur.sensor_id;
    wr_data.above   = cur.above_not_below;
    wr_data.limit   = cur.limit;
    wr_data.band    = cur.band;
    wr_data.pin     = cur.pin;

    trig_next = trig;
    if (hit && !stall) begin
      trig_next[scan_idx] = ~trig[scan_idx];
    end
    if (wr_en) begin
      trig_next[used[IW-1:0]] = 1'b0;
    end
    trig_pad  = PW'(trig_next);
    mask_next = trig_pad[MASK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      trig       <= '0;
      scan_idx   <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      trig <= trig_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (items.valid) begin
            cur.operation       <= op_t'(items.operation);
            cur.sensor_id       <= items.sensor_id;
            cur.sample_value    <= items.sample_value;
            cur.above_not_below <= items.above_not_below;
            cur.limit           <= items.limit;
            cur.band            <= items.band;
            cur.pin             <= items.pin;
            scan_idx            <= '0;
            cnt                 <= '0;
            state <= (op_t'(items.operation) == OP_ADD) ? S_ADD : S_SCAN;
          end
        end
        S_ADD: begin
          if (out_free) begin
            out_res.triggered_mask     <= mask_next;
            out_res.level              <= 1'b0;
            out_res.last               <= 1'b1;
            if (full) begin
              out_res.kind       <= KIND_FULL;
              out_res.slot_index <= '0;
              out_res.out_pin    <= '0;
            end else begin
              out_res.kind       <= KIND_ADD_OK;
              out_res.slot_index <= IDX_W'(used);
              out_res.out_pin    <= cur.pin;
              used               <= used + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (!in_range) begin
            state <= S_FLUSH;
          end else if (!stall) begin
            if (hit && cnt < CNT_W'(MAX_RESULTS)) begin
              // hand the held result on, then hold this one until we know if it is the last
              if (pend_valid) begin
                out_res <= pend;
              end
              pend.kind           <= KIND_CHANGE;
              pend.slot_index     <= IDX_W'(scan_idx);
              pend.out_pin        <= rd_data.pin;
              pend.level          <= ~trig[scan_idx];
              pend.triggered_mask <= mask_next;
              pend.last           <= 1'b0;
              pend_valid          <= 1'b1;
              cnt                 <= cnt + CNT_W'(1);
            end
            if (is_final) begin
              state <= S_FLUSH;
            end else begin
              scan_idx <= scan_idx + IW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_res.kind           <= pend.kind;
            out_res.slot_index     <= pend.slot_index;
            out_res.out_pin        <= pend.out_pin;
            out_res.level          <= pend.level;
            out_res.triggered_mask <= pend.triggered_mask;
            out_res.last           <= 1'b1;
            pend_valid             <= 1'b0;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign items.ready            = (state == S_IDLE);
  assign results.valid          = out_valid;
  assign results.kind           = out_res.kind;
  assign results.slot_index     = out_res.slot_index;
  assign results.out_pin        = out_res.out_pin;
  assign results.level          = out_res.level;
  assign results.triggered_mask = out_res.triggered_mask;
  assign results.last           = out_res.last;

`ifndef NO_ASSERTIONS
  // table fill never passes the slot count
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(ALERT_SLOTS))
    else $error("slot fill count beyond table size");

  // a held change result only exists while a sample is in progress
  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_SCAN || state == S_FLUSH))
    else $error("held result outside a sample scan");

  // no more than eight change results per sample
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond limit");

  // an add on a full table produces a rejection on the next cycle
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD && out_free && full) |=>
      (results.valid && results.kind == KIND_FULL && results.last))
    else $error("full table add not rejected");
`endif

endmodule

### src/mhal_slot_ram.sv
module mhal_slot_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  mhal_pkg::slot_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output mhal_pkg::slot_t rd_data
);
  import mhal_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/mhal_eval.sv
module mhal_eval (
  input  mhal_pkg::slot_t    slot,
  input  logic               triggered,
  input  logic [7:0]         sensor_id,
  input  logic signed [31:0] sample_value,
  output logic               hit
);
  import mhal_pkg::*;

  logic signed [33:0] value_x;
  logic signed [33:0] limit_x;
  logic signed [33:0] band_x;
  logic signed [33:0] target;
  logic               want_gt;
  logic               change;

  always_comb begin
    value_x = 34'(sample_value);
    limit_x = 34'(slot.limit);
    band_x  = signed'({3'b000, slot.band});
    // release point sits one band past the limit, away from the alarm side
    if (!triggered) begin
      target = limit_x;
    end else if (slot.above) begin
      target = limit_x - band_x;
    end else begin
      target = limit_x + band_x;
    end
    want_gt = slot.above ^ triggered;
    change  = want_gt ? (value_x > target) : (value_x < target);
    hit     = (slot.sensor == sensor_id) && change;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

// self-checking bench for the hysteresis alarm table: a cycle-free predictor
// tracks the slot table and the triggered flags, every accepted item queues the
// results it must cause, and every result transfer is checked against the queue
module testbench;
  import mhal_pkg::*;

  localparam int ALERT_SLOTS    = 8;
  localparam int HOLDOFF_CYCLES = 120;   // long result-side hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 20;    // a full eight-slot scan fits well inside
  localparam int REPORT_LIMIT   = 10;
  localparam logic [7:0] WATCHED_SENSOR = 8'h05;

  // one input item as the bench sees it; unused fields carry junk on purpose
  typedef struct {
    op_t                op;
    logic [7:0]         sensor;
    logic signed [31:0] value;
    logic               above;
    logic signed [31:0] limit;
    logic [30:0]        band;
    logic [7:0]         pin;
  } alarm_item_t;

  logic clk;
  logic rst;

  mhal_item_if   items_bus();
  mhal_result_if results_bus();

  multichannel_hysteresis_alarm #(
    .ALERT_SLOTS(ALERT_SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_bus),
    .results(results_bus)
  );

  // predictor state: the slot table, how much of it is used, and the flags
  slot_t             watch_table [ALERT_SLOTS];
  int                watch_count;
  logic [MASK_W-1:0] alarm_flags;
  res_t              pending_alarm_results [$];

  // values that sit on or next to the thresholds of the fixed slots
  int boundary_values [11] = '{
    0, 1, -1, 32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0001,
    32'sh0010_0000, 32'sh0010_0001, -32'sh0008_0000, 32'sh7FFF_FFFF, 32'sh8000_0000
  };

  int  burst_left;
  bit  holdoff_request;
  int  holdoffs_done;
  int  items_sent, adds_sent, samples_sent;
  int  results_checked, level_changes, adds_rejected;
  int  fault_count;
  int  stall_cycles;

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: work out the results one accepted item must cause
  // ---------------------------------------------------------------------------
  function automatic void predict_alarm_item(input alarm_item_t it);
    res_t    r;
    res_t    held;
    bit      have_held;
    bit      flips;
    bit      next_level;
    longint  v, lim, bw;
    int      i;
    r = '0;
    held = '0;
    have_held = 1'b0;
    if (it.op == OP_ADD) begin
      r.kind = KIND_FULL;
      if (watch_count < ALERT_SLOTS) begin
        watch_table[watch_count] = '{sensor: it.sensor, above: it.above, limit: it.limit,
                                     band: it.band, pin: it.pin};
        alarm_flags[watch_count] = 1'b0;
        r.kind       = KIND_ADD_OK;
        r.slot_index = IDX_W'(watch_count);
        r.out_pin    = it.pin;
        watch_count++;
      end else begin
        adds_rejected++;
      end
      r.triggered_mask = alarm_flags;
      r.last           = 1'b1;
      pending_alarm_results.push_back(r);
    end else begin
      // 64-bit compares, so limit -/+ band never wraps
      v = longint'(signed'(it.value));
      for (i = 0; i < watch_count; i++) begin
        if (watch_table[i].sensor == it.sensor) begin
          lim = longint'(signed'(watch_table[i].limit));
          bw  = longint'({33'd0, watch_table[i].band});
          flips = 1'b0;
          next_level = 1'b0;
          if (watch_table[i].above) begin
            if (!alarm_flags[i] && v > lim) begin
              flips = 1'b1;
              next_level = 1'b1;
            end else if (alarm_flags[i] && v < lim - bw) begin
              flips = 1'b1;
            end
          end else begin
            if (!alarm_flags[i] && v < lim) begin
              flips = 1'b1;
              next_level = 1'b1;
            end else if (alarm_flags[i] && v > lim + bw) begin
              flips = 1'b1;
            end
          end
          if (flips) begin
            alarm_flags[i] = next_level;
            level_changes++;
            // hold back one result so the final one can get its last mark
            if (have_held) pending_alarm_results.push_back(held);
            held = '0;
            held.kind           = KIND_CHANGE;
            held.slot_index     = IDX_W'(i);
            held.out_pin        = watch_table[i].pin;
            held.level          = next_level;
            held.triggered_mask = alarm_flags;
            have_held = 1'b1;
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        pending_alarm_results.push_back(held);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // item builders; fields the operation ignores get random junk
  // ---------------------------------------------------------------------------
  function automatic alarm_item_t make_add(input logic [7:0] sensor, input logic above,
                                           input logic signed [31:0] limit,
                                           input logic [30:0] band, input logic [7:0] pin);
    alarm_item_t it;
    it = '{op: OP_ADD, sensor: sensor, value: 32'($urandom), above: above, limit: limit,
           band: band, pin: pin};
    return it;
  endfunction

  function automatic alarm_item_t make_sample(input logic [7:0] sensor,
                                              input logic signed [31:0] value);
    alarm_item_t it;
    it = '{op: OP_SAMPLE, sensor: sensor, value: value, above: 1'($urandom),
           limit: 32'($urandom), band: 31'($urandom), pin: 8'($urandom)};
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps between them; entered and
  // left at a falling edge so valid is never lowered and raised in one step
  // ---------------------------------------------------------------------------
  task automatic send_item(input alarm_item_t it);
    if (burst_left == 0) begin
      items_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(1, 8);
    end
    items_bus.valid           <= 1'b1;
    items_bus.operation       <= it.op;
    items_bus.sensor_id       <= it.sensor;
    items_bus.sample_value    <= it.value;
    items_bus.above_not_below <= it.above;
    items_bus.limit           <= it.limit;
    items_bus.band            <= it.band;
    items_bus.pin             <= it.pin;
    @(posedge clk);
    while (!items_bus.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (it.op == OP_ADD) adds_sent++;
    else samples_sent++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // fill all slots on one sensor; fixed slots cover the field extremes, the
  // last three are random but chosen so that a reading of 0.5 sets every flag
  task automatic test_fill_table();
    int  k;
    logic dir;
    logic signed [31:0] lim;
    send_item(make_add(WATCHED_SENSOR, 1'b1, 32'sh0000_0000, 31'h0001_0000, 8'hFF));
    send_item(make_add(WATCHED_SENSOR, 1'b0, 32'sh0010_0000, 31'h0000_0000, 8'h00));
    // set by anything above the minimum, can never clear without wrap
    send_item(make_add(WATCHED_SENSOR, 1'b1, 32'sh8000_0000, 31'h7FFF_FFFF, 8'hA5));
    // set by anything below the maximum, can never clear without wrap
    send_item(make_add(WATCHED_SENSOR, 1'b0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 8'h5A));
    send_item(make_add(WATCHED_SENSOR, 1'b1, -32'sh0008_0000, 31'h0002_0000, 8'h03));
    for (k = 0; k < 3; k++) begin
      dir = 1'($urandom);
      lim = dir ? -32'($urandom_range(1, 32'h0010_0000))
                : 32'($urandom_range(32'h0001_0000, 32'h0010_0000));
      send_item(make_add(WATCHED_SENSOR, dir, lim, 31'($urandom_range(0, 32'h0004_0000)),
                         8'($urandom)));
    end
  endtask

  // crossings, hysteresis edges, no-change and no-match samples
  task automatic test_alarm_levels();
    send_item(make_sample(WATCHED_SENSOR, 32'sh0000_8000));   // all eight flags set
    send_item(make_sample(WATCHED_SENSOR, 32'sh0000_8000));   // nothing changes
    send_item(make_sample(WATCHED_SENSOR, 32'sh7FFF_FFFF));
    send_item(make_sample(WATCHED_SENSOR, 32'sh8000_0000));
    send_item(make_sample(WATCHED_SENSOR, 32'sh0000_0000));   // equal to a limit: no set
    send_item(make_sample(WATCHED_SENSOR, 32'sh0000_0001));
    send_item(make_sample(WATCHED_SENSOR, -32'sh0001_0000));  // right on the band edge
    send_item(make_sample(WATCHED_SENSOR, -32'sh0001_0001));  // just past it
    send_item(make_sample(8'h00, 32'sh7FFF_FFFF));            // no slot watches these
    send_item(make_sample(8'hFF, 32'sh8000_0000));
  endtask

  task automatic test_table_full();
    send_item(make_add(8'hFF, 1'b1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 8'hFF));
    send_item(make_add(8'h00, 1'b0, 32'sh8000_0000, 31'h0000_0000, 8'h00));
  endtask

  // results held off for a long stretch while samples keep coming
  task automatic test_result_backpressure();
    int k;
    holdoff_request = 1'b1;
    for (k = 0; k < 12; k++)
      send_item(make_sample(WATCHED_SENSOR, k[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF));
  endtask

  task automatic test_random_traffic(input int count);
    alarm_item_t it;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)
        it = make_add(8'($urandom), 1'($urandom), 32'($urandom), 31'($urandom), 8'($urandom));
      else if (pick < 22)
        it = make_sample(8'($urandom), 32'($urandom));
      else if (pick < 37)
        it = make_sample(WATCHED_SENSOR, boundary_values[$urandom_range(0, 10)]);
      else if (pick < 47)
        it = make_sample(WATCHED_SENSOR, 32'($urandom));
      else
        // mostly readings within +/-20.0, where the fixed and random slots switch
        it = make_sample(WATCHED_SENSOR, int'($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000);
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    logic [15:0] stall_pattern;
    int          pattern_left;
    int          hold_left;
    results_bus.ready = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        hold_left = HOLDOFF_CYCLES;
        holdoffs_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_bus.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          // a quarter of the time no stalls at all
          stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
          pattern_left = 40;
        end
        pattern_left--;
        results_bus.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results, predict accepted items, watch for a hang
  // ---------------------------------------------------------------------------
  task automatic log_fault(input string msg);
    if (fault_count < REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
    fault_count++;
  endtask

  always @(posedge clk) begin : monitor
    res_t        got;
    res_t        want;
    alarm_item_t seen;
    bit          moved;
    if (!rst) begin
      moved = 1'b0;
      // results first: an item's own results can never come in its transfer cycle
      if (results_bus.valid && results_bus.ready) begin
        moved = 1'b1;
        results_checked++;
        got.kind           = kind_t'(results_bus.kind);
        got.slot_index     = results_bus.slot_index;
        got.out_pin        = results_bus.out_pin;
        got.level          = results_bus.level;
        got.triggered_mask = results_bus.triggered_mask;
        got.last           = results_bus.last;
        if (pending_alarm_results.size() == 0) begin
          log_fault($sformatf("result kind %0d slot %0d with nothing expected",
                              got.kind, got.slot_index));
        end else begin
          want = pending_alarm_results.pop_front();
          if (got.kind !== want.kind || got.slot_index !== want.slot_index ||
              got.out_pin !== want.out_pin || got.level !== want.level ||
              got.triggered_mask !== want.triggered_mask || got.last !== want.last)
            log_fault($sformatf({"kind %0d/%0d slot %0d/%0d pin %h/%h level %0b/%0b ",
                                 "mask %h/%h last %0b/%0b (expected/actual)"},
                                want.kind, got.kind, want.slot_index, got.slot_index,
                                want.out_pin, got.out_pin, want.level, got.level,
                                want.triggered_mask, got.triggered_mask,
                                want.last, got.last));
        end
      end
      if (items_bus.valid && items_bus.ready) begin
        moved = 1'b1;
        seen.op     = op_t'(items_bus.operation);
        seen.sensor = items_bus.sensor_id;
        seen.value  = items_bus.sample_value;
        seen.above  = items_bus.above_not_below;
        seen.limit  = items_bus.limit;
        seen.band   = items_bus.band;
        seen.pin    = items_bus.pin;
        predict_alarm_item(seen);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_alarm_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst = 1'b1;
    items_bus.valid           = 1'b0;
    items_bus.operation       = OP_ADD;
    items_bus.sensor_id       = '0;
    items_bus.sample_value    = '0;
    items_bus.above_not_below = 1'b0;
    items_bus.limit           = '0;
    items_bus.band            = '0;
    items_bus.pin             = '0;
    watch_count   = 0;
    alarm_flags   = '0;
    burst_left    = 0;
    stall_cycles  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_fill_table();
    test_alarm_levels();
    test_table_full();
    test_result_backpressure();
    test_random_traffic(68);
    items_bus.valid <= 1'b0;

    // the watchdog bounds this wait
    while (pending_alarm_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_alarm_results.size() != 0)
      log_fault($sformatf("%0d results never arrived", pending_alarm_results.size()));

    $display("summary: %0d items (%0d adds, %0d rejected; %0d samples), %0d results checked",
             items_sent, adds_sent, adds_rejected, samples_sent, results_checked);
    $display("summary: %0d alarm level changes, %0d long result hold-offs, %0d mismatches",
             level_changes, holdoffs_done, fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
